// File: rtl/core/pairwise_contingency_counter_defines.svh
// shared assertion macros for the contingency counter
// both expect clk and rst_n in the scope of the use
`ifndef PAIRWISE_CONTINGENCY_COUNTER_DEFINES_SVH
`define PAIRWISE_CONTINGENCY_COUNTER_DEFINES_SVH

// same-cycle implication
`define PCC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/pcc_pkg.sv
package pcc_pkg;

  // fixed field widths
  localparam int VALUE_FIELDS = 4;
  localparam int VALUE_W      = 5;
  localparam int VALUE_MAX    = (1 << VALUE_W) - 1;
  localparam int ATTR_W       = 3;
  localparam int PAIR_W       = 3;
  localparam int ROWCOL_W     = 4;
  localparam int WORD32_W     = 32;
  localparam int STATUS_W     = 2;
  localparam int OPCODE_W     = 2;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 5;

  // pair slots of the four value fields, ordered so that the pairs of the
  // first n attributes come first
  localparam int PAIR_MAX = VALUE_FIELDS * (VALUE_FIELDS - 1) / 2;
  localparam int SLOT_W   = $clog2(PAIR_MAX);
  localparam logic [1:0] SLOT_I [PAIR_MAX] = '{2'd0, 2'd0, 2'd1, 2'd0, 2'd1, 2'd2};
  localparam logic [1:0] SLOT_J [PAIR_MAX] = '{2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3};

  // reset values of the registers
  localparam logic [ATTR_W-1:0]  ATTR_RESET = 3'd2;
  localparam logic [VALUE_W-1:0] SIZE_RESET = 5'd16;
  localparam logic [ATTR_W-1:0]  ATTR_MIN   = 3'd2;

  localparam logic [WORD32_W-1:0] RECORDS_MAX = 32'hFFFF_FFFF;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_COUNT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 2'd2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_ATTR_COUNT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_0     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_1     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_2     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_3     = 3'd4;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [VALUE_W-1:0]  value0;
    logic [VALUE_W-1:0]  value1;
    logic [VALUE_W-1:0]  value2;
    logic [VALUE_W-1:0]  value3;
    logic [PAIR_W-1:0]   read_pair;
    logic [ROWCOL_W-1:0] read_row;
    logic [ROWCOL_W-1:0] read_col;
  } pcc_in_t;

  typedef struct packed {
    logic [WORD32_W-1:0] cell_count;
    logic [WORD32_W-1:0] record_total;
    logic [STATUS_W-1:0] status;
  } pcc_out_t;

  // commands to the count store
  typedef struct packed {
    logic inc;
    logic clr;
    logic rd;
  } pcc_store_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_COUNT,
    S_LOOKUP,
    S_WAIT
  } pcc_state_t;

  // lexicographic pair number of attributes (i,j) among the first n
  function automatic logic [PAIR_W-1:0] pair_number(input logic [ATTR_W-1:0] n,
                                                    input logic [1:0] i,
                                                    input logic [1:0] j);
    logic [4:0] k;
    k = 5'(i) * 5'(n) - ((5'(i) * (5'(i) + 5'd1)) >> 1) + 5'(j) - 5'(i) - 5'd1;
    return k[PAIR_W-1:0];
  endfunction

  // number of pairs among the first n attributes
  function automatic logic [PAIR_W-1:0] pair_total(input logic [ATTR_W-1:0] n);
    logic [4:0] t;
    t = (5'(n) * (5'(n) - 5'd1)) >> 1;
    return t[PAIR_W-1:0];
  endfunction

endpackage

// File: rtl/core/pcc_store.sv
`include "pairwise_contingency_counter_defines.svh"

module pcc_store #(
  parameter int DEPTH       = 1536,
  parameter int ADDR_W      = 11,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pcc_pkg::pcc_store_ctl_t ctl,
  input  logic [ADDR_W-1:0]       addr,
  output logic [COUNT_WIDTH-1:0]  rd_data
);
  import pcc_pkg::*;

  logic [COUNT_WIDTH-1:0] mem [DEPTH];
  logic [COUNT_WIDTH-1:0] q_r;
  logic                   wb_vld_r;
  logic [ADDR_W-1:0]      wb_addr_r;
  logic [COUNT_WIDTH-1:0] wb_data;
  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data;

  // saturating increment of the cell read last cycle
  assign wb_data = (q_r == '1) ? q_r : q_r + COUNT_WIDTH'(1);

  // one write port shared by clear and write-back
  assign wr_en   = ctl.clr || wb_vld_r;
  assign wr_addr = ctl.clr ? addr : wb_addr_r;
  assign wr_data = ctl.clr ? '0 : wb_data;

  // memory array, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.inc || ctl.rd) begin
      q_r <= mem[addr];
    end
  end

  // write-back stage of the increment
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_vld_r <= 1'b0;
    end else begin
      wb_vld_r <= ctl.inc;
    end
  end

  always_ff @(posedge clk) begin
    wb_addr_r <= addr;
  end

  assign rd_data = q_r;

  `PCC_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0({ctl.inc, ctl.clr, ctl.rd}),
                  "more than one store command at once")
  `PCC_ASSERT_NOW(a_clr_no_wb, ctl.clr, !wb_vld_r,
                  "clear collides with increment write-back")
  `PCC_ASSERT_NOW(a_no_stale_read, (ctl.inc || ctl.rd) && wb_vld_r, addr != wb_addr_r,
                  "read of a cell whose write-back is still pending")

endmodule

// File: rtl/core/pairwise_contingency_counter.sv
// Pairwise contingency counter. Raise start with a word on in_word while busy is low;
// each accepted word gives exactly one result word, shown on out_word for one cycle
// with out_valid high; the receiver cannot stall, so it must take the word in that
// cycle. A count record steps through the n(n-1)/2 attribute pairs in use (1 to 6)
// and raises the result strobe after the last one: the pair increments go one per cycle
// through the single read-modify-write port of the count memory, and the next word
// may be accepted at the edge that ends the result cycle. A cell read passes through
// the LOOKUP state, which issues the registered memory read, and the WAIT state, which
// forms its result. A clear, and the pass that runs after reset, sweep the whole memory
// one cell per cycle, PAIR_SLOTS * MAX_CATEGORIES^2 cells (1536 with the defaults),
// with busy high and no result for the reset pass.
// Register writes are always taken (cfg_ready stays high) and should be made only
// while the block is idle.
`include "pairwise_contingency_counter_defines.svh"

module pairwise_contingency_counter #(
  parameter int MAX_ATTRIBUTES = 4,
  parameter int MAX_CATEGORIES = 16,
  parameter int COUNT_WIDTH    = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  pcc_pkg::pcc_in_t                 in_word,
  output logic                             out_valid,
  output pcc_pkg::pcc_out_t                out_word,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pcc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pcc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pcc_pkg::*;

  localparam int PAIR_SLOTS  = MAX_ATTRIBUTES * (MAX_ATTRIBUTES - 1) / 2;
  localparam int TABLE_CELLS = MAX_CATEGORIES * MAX_CATEGORIES;
  localparam int STORE_CELLS = PAIR_SLOTS * TABLE_CELLS;
  localparam int ADDR_W      = $clog2(STORE_CELLS);
  localparam int ATTR_TOP    = (MAX_ATTRIBUTES < VALUE_FIELDS) ? MAX_ATTRIBUTES : VALUE_FIELDS;
  localparam int SIZE_CAP    = (MAX_CATEGORIES < VALUE_MAX) ? MAX_CATEGORIES : VALUE_MAX;

  // configuration
  logic [ATTR_W-1:0]  attr_count_r;
  logic [VALUE_W-1:0] size_r [VALUE_FIELDS];
  logic [ATTR_W-1:0]  n_eff;
  logic [VALUE_W-1:0] eff_size [VALUE_FIELDS];

  // word decode
  logic               in_take;
  logic [VALUE_W-1:0] vals [VALUE_FIELDS];
  logic [VALUE_W-1:0] vals_m1 [VALUE_FIELDS];
  logic               val_ok [VALUE_FIELDS];
  logic               above;
  logic               slot_go [PAIR_MAX];
  logic [ADDR_W-1:0]  slot_addr [PAIR_MAX];
  logic               rd_hit;
  logic [ADDR_W-1:0]  rd_addr;

  // latched work
  logic [STATUS_W-1:0] stat_r;
  logic                slot_go_r [PAIR_MAX];
  logic [ADDR_W-1:0]   slot_addr_r [PAIR_MAX];
  logic                rd_ok_r;
  logic [ADDR_W-1:0]   rd_addr_r;
  logic [SLOT_W-1:0]   s_r;
  logic [ADDR_W-1:0]   clr_addr_r;
  logic                sweep_emit_r;
  logic [WORD32_W-1:0] rec_r;

  // control
  pcc_state_t      state_r, state_nxt;
  logic            emit;
  pcc_out_t        out_nxt;
  pcc_out_t        out_word_r;
  logic            out_valid_r;
  pcc_store_ctl_t  store_ctl;
  logic [ADDR_W-1:0]      store_addr;
  logic [COUNT_WIDTH-1:0] store_q;
  logic            count_last;
  logic            sweep_last;

  assign in_take   = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_count_r <= ATTR_RESET;
      for (int a = 0; a < VALUE_FIELDS; a++) begin
        size_r[a] <= SIZE_RESET;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ATTR_COUNT: attr_count_r <= cfg_data[ATTR_W-1:0];
        CFG_SIZE_0:     size_r[0] <= cfg_data;
        CFG_SIZE_1:     size_r[1] <= cfg_data;
        CFG_SIZE_2:     size_r[2] <= cfg_data;
        CFG_SIZE_3:     size_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // attributes in use and clamped sizes
  always_comb begin
    if (attr_count_r < ATTR_MIN) begin
      n_eff = ATTR_MIN;
    end else if (attr_count_r > ATTR_W'(ATTR_TOP)) begin
      n_eff = ATTR_W'(ATTR_TOP);
    end else begin
      n_eff = attr_count_r;
    end
    for (int a = 0; a < VALUE_FIELDS; a++) begin
      eff_size[a] = (size_r[a] > VALUE_W'(SIZE_CAP)) ? VALUE_W'(SIZE_CAP) : size_r[a];
    end
  end

  assign vals[0] = in_word.value0;
  assign vals[1] = in_word.value1;
  assign vals[2] = in_word.value2;
  assign vals[3] = in_word.value3;

  // record decode: valid values, range status, one address per pair slot
  always_comb begin
    above = 1'b0;
    for (int a = 0; a < VALUE_FIELDS; a++) begin
      vals_m1[a] = vals[a] - VALUE_W'(1);
      val_ok[a]  = 1'b0;
      if (ATTR_W'(a) < n_eff) begin
        if (vals[a] > eff_size[a]) begin
          above = 1'b1;
        end else begin
          val_ok[a] = (vals[a] != '0);
        end
      end
    end
    for (int s = 0; s < PAIR_MAX; s++) begin
      slot_go[s]   = val_ok[SLOT_I[s]] && val_ok[SLOT_J[s]];
      slot_addr[s] = ADDR_W'(pair_number(n_eff, SLOT_I[s], SLOT_J[s])) * ADDR_W'(TABLE_CELLS)
                   + ADDR_W'(vals_m1[SLOT_I[s]]) * ADDR_W'(MAX_CATEGORIES)
                   + ADDR_W'(vals_m1[SLOT_J[s]]);
    end
  end

  // read decode: pair in use and row/col within the attribute sizes
  always_comb begin
    rd_hit = 1'b0;
    for (int s = 0; s < PAIR_MAX; s++) begin
      if ((pair_number(n_eff, SLOT_I[s], SLOT_J[s]) == in_word.read_pair)
          && (ATTR_W'(SLOT_J[s]) < n_eff)
          && (VALUE_W'(in_word.read_row) < eff_size[SLOT_I[s]])
          && (VALUE_W'(in_word.read_col) < eff_size[SLOT_J[s]])) begin
        rd_hit = 1'b1;
      end
    end
    rd_addr = ADDR_W'(in_word.read_pair) * ADDR_W'(TABLE_CELLS)
            + ADDR_W'(in_word.read_row) * ADDR_W'(MAX_CATEGORIES)
            + ADDR_W'(in_word.read_col);
  end

  // capture the decoded word
  always_ff @(posedge clk) begin
    if (in_take) begin
      stat_r    <= above ? ST_RANGE : ST_OK;
      rd_ok_r   <= rd_hit;
      rd_addr_r <= rd_addr;
      for (int s = 0; s < PAIR_MAX; s++) begin
        slot_go_r[s]   <= slot_go[s];
        slot_addr_r[s] <= slot_addr[s];
      end
    end
  end

  // pair slot and sweep counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r          <= '0;
      clr_addr_r   <= '0;
      sweep_emit_r <= 1'b0;
    end else if (in_take) begin
      s_r          <= '0;
      clr_addr_r   <= '0;
      sweep_emit_r <= (in_word.opcode == OP_CLEAR);
    end else begin
      if (state_r == S_COUNT) begin
        s_r <= s_r + SLOT_W'(1);
      end
      if (state_r == S_SWEEP) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
    end
  end

  // record total, saturating
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r <= '0;
    end else if (in_take) begin
      if (in_word.opcode == OP_COUNT) begin
        if (rec_r != RECORDS_MAX) begin
          rec_r <= rec_r + WORD32_W'(1);
        end
      end else if (in_word.opcode == OP_CLEAR) begin
        rec_r <= '0;
      end
    end
  end

  assign count_last = (PAIR_W'(s_r) == pair_total(n_eff) - PAIR_W'(1));
  assign sweep_last = (clr_addr_r == ADDR_W'(STORE_CELLS - 1));

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state, store commands and result word
  always_comb begin
    state_nxt           = state_r;
    emit                = 1'b0;
    out_nxt.cell_count   = '0;
    out_nxt.record_total = rec_r;
    out_nxt.status       = ST_OK;
    store_ctl           = '0;
    store_addr          = slot_addr_r[s_r];
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          unique case (in_word.opcode)
            OP_COUNT: state_nxt = S_COUNT;
            OP_CLEAR: state_nxt = S_SWEEP;
            OP_READ:  state_nxt = S_LOOKUP;
            default:  emit = 1'b1;
          endcase
        end
      end
      S_COUNT: begin
        store_ctl.inc = slot_go_r[s_r];
        if (count_last) begin
          state_nxt      = S_IDLE;
          emit           = 1'b1;
          out_nxt.status = stat_r;
        end
      end
      S_SWEEP: begin
        store_ctl.clr = 1'b1;
        store_addr    = clr_addr_r;
        if (sweep_last) begin
          state_nxt = S_IDLE;
          emit      = sweep_emit_r;
        end
      end
      S_LOOKUP: begin
        store_ctl.rd = rd_ok_r;
        store_addr   = rd_addr_r;
        state_nxt    = S_WAIT;
      end
      S_WAIT: begin
        state_nxt = S_IDLE;
        emit      = 1'b1;
        if (rd_ok_r) begin
          out_nxt.cell_count = WORD32_W'(store_q);
        end else begin
          out_nxt.status = ST_BAD_ADDR;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // count memory with read-modify-write
  pcc_store #(
    .DEPTH       (STORE_CELLS),
    .ADDR_W      (ADDR_W),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (store_ctl),
    .addr    (store_addr),
    .rd_data (store_q)
  );

  `PCC_ASSERT_NOW(a_sweep_silent, state_r == S_SWEEP, !out_valid_r,
                  "result strobe while the memory is being cleared")
  `PCC_ASSERT_NEXT(a_rec_counted, in_take && (in_word.opcode == OP_COUNT), rec_r != '0,
                   "record total still zero after a counted record")
  `PCC_ASSERT_NOW(a_slot_bound, state_r == S_COUNT, PAIR_W'(s_r) < pair_total(n_eff),
                  "pair sequencer ran past the pairs in use")

endmodule

// File: test/pcc_tally_checker.sv
module pcc_tally_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  pcc_pkg::pcc_in_t                in_word,
  input  logic                            out_valid,
  input  pcc_pkg::pcc_out_t               out_word,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [pcc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pcc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              mismatches,
  output int                              reports_due_n,
  output int                              reports_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import pcc_pkg::*;

  localparam int CATS        = 16;
  localparam int PAIR_SLOTS  = 6;
  localparam int TABLE_CELLS = CATS * CATS;
  localparam int STORE_CELLS = PAIR_SLOTS * TABLE_CELLS;
  localparam logic [WORD32_W-1:0] COUNT_TOP = '1;

  // local copy of the count store and registers
  logic [WORD32_W-1:0] tally [STORE_CELLS];
  logic [WORD32_W-1:0] records;
  logic [ATTR_W-1:0]   attr_reg;
  logic [VALUE_W-1:0]  size_reg [VALUE_FIELDS];
  pcc_out_t            reports_due [$];

  // attributes in use, clamped to 2..4
  function automatic int attrs_active();
    int n;
    n = int'(attr_reg);
    if (n < 2) n = 2;
    if (n > VALUE_FIELDS) n = VALUE_FIELDS;
    return n;
  endfunction

  // categories of one attribute, clamped to the table size
  function automatic int cats_of(input int a);
    int s;
    s = int'(size_reg[a]);
    return (s > CATS) ? CATS : s;
  endfunction

  function automatic void wipe_store();
    for (int c = 0; c < STORE_CELLS; c++) tally[c] = '0;
    records = '0;
  endfunction

  // append one predicted result at the tail
  function automatic void queue_report(input pcc_out_t r);
    reports_due.insert(reports_due.size(), r);
  endfunction

  // apply one word to the local store and build the result it gives
  function automatic pcc_out_t tally_word(input pcc_in_t w);
    pcc_out_t r;
    int       n;
    int       k;
    int       addr;
    int       v [VALUE_FIELDS];
    bit       ok [VALUE_FIELDS];
    bit       found;
    r = '0;
    r.status = ST_OK;
    n = attrs_active();
    case (w.opcode)
      OP_COUNT: begin
        v[0] = int'(w.value0);
        v[1] = int'(w.value1);
        v[2] = int'(w.value2);
        v[3] = int'(w.value3);
        // out-of-range values flag the status and drop their pairs
        for (int i = 0; i < VALUE_FIELDS; i++) begin
          ok[i] = 1'b0;
          if (i < n) begin
            if (v[i] > cats_of(i)) r.status = ST_RANGE;
            else ok[i] = (v[i] != 0);
          end
        end
        k = 0;
        for (int i = 0; i < n; i++) begin
          for (int j = i + 1; j < n; j++) begin
            if (ok[i] && ok[j]) begin
              addr = k * TABLE_CELLS + (v[i] - 1) * CATS + (v[j] - 1);
              if (tally[addr] != COUNT_TOP) tally[addr] = tally[addr] + WORD32_W'(1);
            end
            k++;
          end
        end
        if (records != RECORDS_MAX) records = records + WORD32_W'(1);
      end
      OP_CLEAR: wipe_store();
      OP_READ: begin
        r.status = ST_BAD_ADDR;
        found = 1'b0;
        k = 0;
        for (int i = 0; i < n && !found; i++) begin
          for (int j = i + 1; j < n && !found; j++) begin
            if (k == int'(w.read_pair)) begin
              found = 1'b1;
              if (int'(w.read_row) < cats_of(i) && int'(w.read_col) < cats_of(j)) begin
                r.cell_count = tally[k * TABLE_CELLS + int'(w.read_row) * CATS
                                     + int'(w.read_col)];
                r.status = ST_OK;
              end
            end
            k++;
          end
        end
      end
      default: ;
    endcase
    r.record_total = records;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [WORD32_W-1:0] want,
                             input logic [WORD32_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // track registers, predict on each accepted word, compare each result word
  always @(posedge clk) begin : watch
    pcc_out_t want;
    if (!rst_n) begin
      wipe_store();
      attr_reg = ATTR_RESET;
      for (int a = 0; a < VALUE_FIELDS; a++) size_reg[a] = SIZE_RESET;
      reports_due.delete();
      reports_due_n <= 0;
      mismatches = 0;
      reports_checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ATTR_COUNT: attr_reg = cfg_data[ATTR_W-1:0];
          CFG_SIZE_0:     size_reg[0] = cfg_data;
          CFG_SIZE_1:     size_reg[1] = cfg_data;
          CFG_SIZE_2:     size_reg[2] = cfg_data;
          CFG_SIZE_3:     size_reg[3] = cfg_data;
          default: ;
        endcase
      end
      // a result belongs to an earlier word, so compare before taking a new one
      if (out_valid) begin
        if (reports_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual cell %0d total %0d st %0d",
                   $time, out_word.cell_count, out_word.record_total, out_word.status);
          mismatches++;
        end else begin
          want = reports_due.pop_front();
          check_field("cell_count", want.cell_count, out_word.cell_count);
          check_field("record_total", want.record_total, out_word.record_total);
          check_field("status", WORD32_W'(want.status), WORD32_W'(out_word.status));
          reports_checked++;
        end
      end
      if (start && !busy) queue_report(tally_word(in_word));
      reports_due_n <= reports_due.size();
    end
  end

endmodule

// File: test/pairwise_contingency_counter_tb.sv
module pairwise_contingency_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcc_pkg::*;

  localparam int STALL_LIMIT     = 12000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int PHASES          = 8;
  localparam int WORDS_PER_PHASE = 80;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   start     = 1'b0;
  logic                   busy;
  pcc_in_t                in_word   = '0;
  logic                   out_valid;
  pcc_out_t               out_word;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int mismatches;
  int reports_due_n;
  int reports_checked;
  int stall_cycles   = 0;
  int idle_chance    = 0;
  int settings_used  = 0;
  int sent_by_op [4] = '{0, 0, 0, 0};

  // register values as last written, used only to shape stimulus
  logic [ATTR_W-1:0]  cur_attrs;
  logic [VALUE_W-1:0] cur_size [VALUE_FIELDS];

  always #5 clk = ~clk;

  pairwise_contingency_counter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pcc_tally_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_word         (in_word),
    .out_valid       (out_valid),
    .out_word        (out_word),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .reports_due_n   (reports_due_n),
    .reports_checked (reports_checked)
  );

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic int pairs_in_use();
    int n;
    n = int'(cur_attrs);
    if (n < 2) n = 2;
    if (n > VALUE_FIELDS) n = VALUE_FIELDS;
    return n * (n - 1) / 2;
  endfunction

  function automatic int cats_max(input int a);
    return (cur_size[a] > 16) ? 16 : int'(cur_size[a]);
  endfunction

  // every field random, so fields an opcode ignores still toggle
  function automatic pcc_in_t random_fill();
    pcc_in_t w;
    w.opcode    = OPCODE_W'($urandom);
    w.value0    = VALUE_W'($urandom);
    w.value1    = VALUE_W'($urandom);
    w.value2    = VALUE_W'($urandom);
    w.value3    = VALUE_W'($urandom);
    w.read_pair = PAIR_W'($urandom);
    w.read_row  = ROWCOL_W'($urandom);
    w.read_col  = ROWCOL_W'($urandom);
    return w;
  endfunction

  function automatic pcc_in_t count_word(input logic [VALUE_W-1:0] v0, v1, v2, v3);
    pcc_in_t w;
    w = random_fill();
    w.opcode = OP_COUNT;
    w.value0 = v0;
    w.value1 = v1;
    w.value2 = v2;
    w.value3 = v3;
    return w;
  endfunction

  function automatic pcc_in_t read_word(input logic [PAIR_W-1:0] p,
                                        input logic [ROWCOL_W-1:0] row, col);
    pcc_in_t w;
    w = random_fill();
    w.opcode    = OP_READ;
    w.read_pair = p;
    w.read_row  = row;
    w.read_col  = col;
    return w;
  endfunction

  function automatic pcc_in_t bare_word(input logic [OPCODE_W-1:0] op);
    pcc_in_t w;
    w = random_fill();
    w.opcode = op;
    return w;
  endfunction

  // mostly valid categories, a few hot cells, some out of range
  function automatic logic [VALUE_W-1:0] pick_value(input int a);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return VALUE_W'($urandom_range(0, cats_max(a)));
    if (r < 85) return VALUE_W'($urandom_range(1, 2));
    return VALUE_W'($urandom_range(0, VALUE_MAX));
  endfunction

  function automatic logic [ROWCOL_W-1:0] pick_index();
    return $urandom_range(0, 1) ? ROWCOL_W'($urandom_range(0, 1))
                                : ROWCOL_W'($urandom_range(0, 15));
  endfunction

  function automatic logic [VALUE_W-1:0] random_size();
    return ($urandom_range(0, 4) != 0) ? VALUE_W'($urandom_range(1, 16))
                                       : VALUE_W'($urandom_range(0, VALUE_MAX));
  endfunction

  function automatic pcc_in_t random_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return bare_word(OP_CLEAR);
    if (r < 5) return bare_word(OP_UNUSED);
    if (r < 30) begin
      if ($urandom_range(0, 4) != 0)
        return read_word(PAIR_W'($urandom_range(0, pairs_in_use() - 1)),
                         pick_index(), pick_index());
      return read_word(PAIR_W'($urandom), ROWCOL_W'($urandom), ROWCOL_W'($urandom));
    end
    return count_word(pick_value(0), pick_value(1), pick_value(2), pick_value(3));
  endfunction

  // hold start until the word is taken, then maybe idle for a burst
  task automatic send_word(input pcc_in_t w);
    start   <= 1'b1;
    in_word <= w;
    sent_by_op[w.opcode]++;
    do @(posedge clk); while (busy);
    if (idle_chance > 0 && $urandom_range(1, 100) <= idle_chance) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // stop sending until every result word is in and the block is idle
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (reports_due_n != 0 || busy);
  endtask

  // write all registers in one burst, optionally the spare indexes too
  task automatic program_regs(input logic [CFG_DATA_W-1:0] attr_data, s0, s1, s2, s3,
                              input bit poke_spare);
    logic [CFG_INDEX_W-1:0] idx;
    int                     last;
    last = poke_spare ? (1 << CFG_INDEX_W) - 1 : int'(CFG_SIZE_3);
    cur_attrs   = attr_data[ATTR_W-1:0];
    cur_size[0] = s0;
    cur_size[1] = s1;
    cur_size[2] = s2;
    cur_size[3] = s3;
    cfg_valid <= 1'b1;
    for (int i = int'(CFG_ATTR_COUNT); i <= last; i++) begin
      idx = CFG_INDEX_W'(i);
      cfg_index <= idx;
      case (idx)
        CFG_ATTR_COUNT: cfg_data <= attr_data;
        CFG_SIZE_0:     cfg_data <= s0;
        CFG_SIZE_1:     cfg_data <= s1;
        CFG_SIZE_2:     cfg_data <= s2;
        CFG_SIZE_3:     cfg_data <= s3;
        default:        cfg_data <= CFG_DATA_W'($urandom);
      endcase
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    cur_attrs = ATTR_RESET;
    for (int a = 0; a < VALUE_FIELDS; a++) cur_size[a] = SIZE_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // reset clearing pass
    drain();

    // directed: two attributes of sixteen categories after reset
    idle_chance = 30;
    send_word(count_word(16, 16, 31, 31));  // unused attributes ignored
    send_word(count_word(1, 1, 0, 0));
    send_word(count_word(0, 5, 0, 0));      // missing value
    send_word(count_word(17, 3, 0, 0));     // value above size
    send_word(read_word(0, 15, 15));
    send_word(read_word(0, 0, 0));
    send_word(read_word(1, 0, 0));          // pair beyond those in use
    send_word(bare_word(OP_UNUSED));
    send_word(bare_word(OP_CLEAR));
    send_word(read_word(0, 15, 15));
    drain();

    // directed: four attributes, minimum, zero and oversized sizes
    program_regs(4, 1, 16, 0, 31, 1'b1);
    send_word(count_word(1, 16, 1, 16));
    send_word(count_word(1, 7, 0, 31));
    send_word(read_word(5, 0, 0));          // attribute with no category
    send_word(read_word(0, 0, 15));
    send_word(read_word(2, 0, 15));
    send_word(read_word(0, 1, 0));          // row past size
    send_word(read_word(6, 0, 0));
    send_word(read_word(7, 15, 15));
    drain();

    // directed: attribute count below and above range
    program_regs(0, 16, 16, 16, 16, 1'b0);
    send_word(read_word(0, 0, 15));
    send_word(read_word(1, 0, 0));
    send_word(count_word(16, 16, 16, 16));
    drain();
    program_regs(7, 16, 16, 16, 16, 1'b0);
    send_word(read_word(5, 15, 15));
    send_word(count_word(16, 16, 16, 16));
    send_word(read_word(5, 15, 15));
    drain();

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: program_regs(4, 16, 16, 16, 16, 1'b0);
        1: program_regs(3, 2, 3, 1, 4, 1'b0);
        2: program_regs(5'b11010, 1, 1, 1, 1, 1'b0);
        3: program_regs(7, 0, 17, 31, 5, 1'b0);
        4: program_regs(1, CFG_DATA_W'($urandom_range(1, 16)),
                        CFG_DATA_W'($urandom_range(1, 16)),
                        CFG_DATA_W'($urandom_range(1, 16)),
                        CFG_DATA_W'($urandom_range(1, 16)), 1'b0);
        PHASES - 1: program_regs(4, 3, 4, 2, 16, 1'b0);
        default: program_regs(CFG_DATA_W'($urandom_range(0, 31)), random_size(),
                              random_size(), random_size(), random_size(), p[0]);
      endcase
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        // idling comes and goes in stretches, none in the last phase
        if (i % 16 == 0)
          idle_chance = (p == PHASES - 1 || $urandom_range(0, 2) == 0) ? 0 : 35;
        send_word(random_word());
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("sent %0d count, %0d clear, %0d read, %0d unused-opcode words, %0d settings",
             sent_by_op[OP_COUNT], sent_by_op[OP_CLEAR], sent_by_op[OP_READ],
             sent_by_op[OP_UNUSED], settings_used);
    $display("checked %0d result words, %0d mismatches", reports_checked, mismatches);
    if (mismatches == 0 && reports_due_n == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/pcc_pkg.sv
rtl/core/pcc_store.sv
rtl/core/pairwise_contingency_counter.sv
test/pcc_tally_checker.sv
test/pairwise_contingency_counter_tb.sv
